// ===== design/wsd_pkg.sv =====
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types and constants of the WebSocket frame deframer.
// ----------------------------------------------------------------------------
package wsd_pkg;

  localparam int unsigned LenWidth = 64;

  localparam logic [7:0] HdrRsvMask  = 8'h70;
  localparam logic [6:0] LenExt16    = 7'd126;
  localparam logic [6:0] LenExt64    = 7'd127;
  localparam logic [2:0] Ext16Bytes  = 3'd2;
  localparam logic [2:0] Ext64Wrap   = 3'd0;
  localparam logic [2:0] MaskKeyLen  = 3'd4;

  typedef enum logic [2:0] {
    PhHdr1,
    PhHdr2,
    PhExt16,
    PhExt64,
    PhMask,
    PhData
  } phase_e;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       byte_valid;
    logic       frame_last;
    logic [3:0] frame_opcode;
    logic       fin_flag;
    logic       protocol_error;
  } wsd_res_t;

  typedef struct packed {
    logic err_seen;
    logic in_payload;
  } wsd_stat_t;

endpackage

// ===== design/websocket_frame_deframer.sv =====
// Stages: input register, parser logic, result register with a skid entry, so a stalled
// output holds two results. Throughput: one byte per cycle while not stalled.
// Header, length and mask key bytes give only error items and empty-frame end items.
// Reset: parser returns to the first header byte, fin 1, opcode 0, error cleared.
// A reserved-bit error is sticky: all later bytes are dropped until reset.
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Streams WebSocket frame payload bytes, unmasked, with end-of-frame marking.
// ----------------------------------------------------------------------------
module websocket_frame_deframer import wsd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] in_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [7:0] payload_byte, [11:8] frame_opcode,
                                        // [12] fin_flag, [15:13] zero
  output logic [1:0]  m_axis_tuser_o,   // [0] byte_valid, [1] protocol_error
  output logic        m_axis_tlast_o    // frame_last
);

  logic      in_vld;
  logic [7:0] in_byte;
  logic      take;
  logic      push;
  logic      out_rdy;
  wsd_res_t  res;
  wsd_res_t  m_res;
  wsd_stat_t stat;

  assign take = in_vld && out_rdy;

  wsd_in_stage u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .s_byte_i  (s_axis_tdata_i),
    .vld_o     (in_vld),
    .byte_o    (in_byte),
    .take_i    (take)
  );

  wsd_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .byte_i (in_byte),
    .push_o (push),
    .res_o  (res),
    .stat_o (stat)
  );

  wsd_out_skid u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .res_i     (res),
    .rdy_o     (out_rdy),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .m_res_o   (m_res)
  );

  assign m_axis_tdata_o = {3'b000, m_res.fin_flag, m_res.frame_opcode, m_res.payload_byte};
  assign m_axis_tuser_o = {m_res.protocol_error, m_res.byte_valid};
  assign m_axis_tlast_o = m_res.frame_last;

  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> out_rdy)
    else $error("result pushed while output stage full");

  a_no_push_after_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.err_seen |-> !push)
    else $error("result produced after protocol error");

  a_err_item_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[1]) |-> (!m_axis_tuser_o[0] && !m_axis_tlast_o))
    else $error("error item carries data or frame end");

  a_data_only_in_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && res.byte_valid) |-> stat.in_payload)
    else $error("payload byte outside payload phase");

endmodule

// ===== design/wsd_in_stage.sv =====
// ----------------------------------------------------------------------------
// wsd_in_stage
// Input register: holds one stream byte until the parser takes it.
// ----------------------------------------------------------------------------
module wsd_in_stage import wsd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_valid_i,
  output logic       s_ready_o,
  input  logic [7:0] s_byte_i,
  output logic       vld_o,
  output logic [7:0] byte_o,
  input  logic       take_i
);

  logic       vld_q, vld_d;
  logic [7:0] byte_q;

  assign s_ready_o = !vld_q || take_i;
  assign vld_d     = s_ready_o ? s_valid_i : vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_ready_o && s_valid_i) begin
      byte_q <= s_byte_i;
    end
  end

  assign vld_o  = vld_q;
  assign byte_o = byte_q;

endmodule

// ===== design/wsd_parser.sv =====
// ----------------------------------------------------------------------------
// wsd_parser
// Frame header decode, length and mask key capture, payload unmasking.
// ----------------------------------------------------------------------------
module wsd_parser import wsd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       take_i,
  input  logic [7:0] byte_i,
  output logic       push_o,
  output wsd_res_t   res_o,
  output wsd_stat_t  stat_o
);

  phase_e                phase_q, phase_d;
  logic                  fin_q, fin_d;
  logic [3:0]            opcode_q, opcode_d;
  logic                  mask_q, mask_d;
  logic [LenWidth-1:0]   len_q, len_d;
  logic [LenWidth-1:0]   done_q, done_d;
  logic [2:0]            hc_q, hc_d;
  logic [31:0]           key_q, key_d;
  logic                  err_q, err_d;

  logic                  act;
  logic [6:0]            len7;
  logic [2:0]            hc_inc;
  logic [LenWidth-1:0]   len_shift;
  logic [LenWidth-1:0]   len_chk;
  logic [LenWidth-1:0]   done_inc;
  logic                  mask_chk;
  logic                  is_ext;
  logic                  hdr_done;
  logic                  hdr_err;
  logic                  empty_end;
  logic                  data_last;
  logic [7:0]            key_byte;

  assign act       = take_i && !err_q;
  assign len7      = byte_i[6:0];
  assign hc_inc    = hc_q + 3'd1;
  assign len_shift = {len_q[LenWidth-9:0], byte_i};
  assign done_inc  = done_q + {{(LenWidth-1){1'b0}}, 1'b1};
  assign is_ext    = (len7 == LenExt16) || (len7 == LenExt64);
  assign hdr_err   = act && (phase_q == PhHdr1) && (|(byte_i & HdrRsvMask));

  assign hdr_done = act && (((phase_q == PhHdr2) && !is_ext) ||
                            ((phase_q == PhExt16) && (hc_inc == Ext16Bytes)) ||
                            ((phase_q == PhExt64) && (hc_inc == Ext64Wrap)));
  assign len_chk  = (phase_q == PhHdr2) ? {{(LenWidth-7){1'b0}}, len7} : len_shift;
  assign mask_chk = (phase_q == PhHdr2) ? byte_i[7] : mask_q;

  assign empty_end = (hdr_done && !mask_chk && (len_chk == '0)) ||
                     (act && (phase_q == PhMask) && (hc_inc == MaskKeyLen) && (len_q == '0));
  assign data_last = act && (phase_q == PhData) && (done_inc == len_q);

  always_comb begin
    case (done_q[1:0])
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  // next state
  always_comb begin
    phase_d  = phase_q;
    fin_d    = fin_q;
    opcode_d = opcode_q;
    mask_d   = mask_q;
    len_d    = len_q;
    done_d   = done_q;
    hc_d     = hc_q;
    key_d    = key_q;
    err_d    = err_q;
    if (act) begin
      unique case (phase_q)
        PhHdr1: begin
          fin_d    = byte_i[7];
          opcode_d = byte_i[3:0];
          if (hdr_err) begin
            err_d = 1'b1;
          end else begin
            phase_d = PhHdr2;
          end
        end
        PhHdr2: begin
          mask_d = byte_i[7];
          hc_d   = '0;
          if (len7 == LenExt16) begin
            len_d   = '0;
            phase_d = PhExt16;
          end else if (len7 == LenExt64) begin
            len_d   = '0;
            phase_d = PhExt64;
          end else begin
            len_d = len_chk;
          end
        end
        PhExt16, PhExt64: begin
          len_d = len_shift;
          hc_d  = hc_inc;
        end
        PhMask: begin
          key_d = {key_q[23:0], byte_i};
          hc_d  = hc_inc;
          if (hc_inc == MaskKeyLen) begin
            hc_d    = '0;
            phase_d = PhData;
          end
        end
        PhData: begin
          done_d = done_inc;
        end
        default: begin
          phase_d = PhHdr1;
          mask_d  = 1'b0;
          len_d   = '0;
          done_d  = '0;
          hc_d    = '0;
          key_d   = '0;
        end
      endcase
      if (hdr_done) begin
        hc_d    = '0;
        done_d  = '0;
        phase_d = mask_chk ? PhMask : PhData;
      end
      if (empty_end || data_last) begin
        phase_d = PhHdr1;
        mask_d  = 1'b0;
        len_d   = '0;
        done_d  = '0;
        hc_d    = '0;
        key_d   = '0;
      end
    end
  end

  // outputs
  always_comb begin
    push_o                = hdr_err || empty_end || (act && (phase_q == PhData));
    res_o                 = '0;
    res_o.frame_opcode    = opcode_q;
    res_o.fin_flag        = fin_q;
    if (hdr_err) begin
      res_o.frame_opcode   = byte_i[3:0];
      res_o.fin_flag       = byte_i[7];
      res_o.protocol_error = 1'b1;
    end else if (empty_end) begin
      res_o.frame_last = 1'b1;
    end else begin
      res_o.payload_byte = byte_i ^ (mask_q ? key_byte : 8'h00);
      res_o.byte_valid   = 1'b1;
      res_o.frame_last   = data_last;
    end
  end

  assign stat_o.err_seen   = err_q;
  assign stat_o.in_payload = (phase_q == PhData);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhHdr1;
      fin_q    <= 1'b1;
      opcode_q <= '0;
      mask_q   <= 1'b0;
      len_q    <= '0;
      done_q   <= '0;
      hc_q     <= '0;
      key_q    <= '0;
      err_q    <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      fin_q    <= fin_d;
      opcode_q <= opcode_d;
      mask_q   <= mask_d;
      len_q    <= len_d;
      done_q   <= done_d;
      hc_q     <= hc_d;
      key_q    <= key_d;
      err_q    <= err_d;
    end
  end

endmodule

// ===== design/wsd_out_skid.sv =====
// ----------------------------------------------------------------------------
// wsd_out_skid
// Result register with a skid entry; ready toward the parser is registered.
// ----------------------------------------------------------------------------
module wsd_out_skid import wsd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  wsd_res_t res_i,
  output logic     rdy_o,
  output logic     m_valid_o,
  input  logic     m_ready_i,
  output wsd_res_t m_res_o
);

  logic     out_vld_q, out_vld_d;
  logic     skid_vld_q, skid_vld_d;
  wsd_res_t out_q, out_d;
  wsd_res_t skid_q, skid_d;
  logic     load;

  assign load  = !out_vld_q || m_ready_i;
  assign rdy_o = !skid_vld_q;

  always_comb begin
    out_vld_d  = out_vld_q;
    skid_vld_d = skid_vld_q;
    out_d      = out_q;
    skid_d     = skid_q;
    if (load) begin
      if (skid_vld_q) begin
        out_d      = skid_q;
        out_vld_d  = 1'b1;
        skid_vld_d = 1'b0;
      end else begin
        out_d     = res_i;
        out_vld_d = push_i;
      end
    end else if (push_i) begin
      skid_d     = res_i;
      skid_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign m_valid_o = out_vld_q;
  assign m_res_o   = out_q;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the WebSocket frame deframer.
// A short table of directed frames runs first, then random well-formed frames,
// and last a reserved-bit header that latches the protocol error. A predictor
// inside the bench follows every accepted byte. The results it expects are
// queued and compared field by field with the master-side stream. The sender
// idles in bursts and the receiver stalls on patterns of its own. One long
// receiver hold-off fills the block, and one pause lets the result queue drain.
// ----------------------------------------------------------------------------
module tb_top;
  import wsd_pkg::*;

  localparam int ResetCycles = 10;
  localparam int RandItems   = 1800;
  localparam int HoldCycles  = 400;
  localparam int DrainCycles = 8;
  localparam int CycleLimit  = 400000;
  localparam int MaxReports  = 10;
  localparam int HoldAt      = 500;
  localparam int PauseAt     = 1200;

  typedef enum logic {RowPred, RowTyped} row_kind_e;
  typedef enum logic [1:0] {RxOpen, RxRandom, RxSparse, RxToggle} rx_mode_e;

  typedef struct {
    logic [7:0] data;
    row_kind_e  kind;
    wsd_res_t   res;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_tvalid;
  logic [7:0]  s_tdata;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic        m_tready;
  logic [15:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;

  websocket_frame_deframer u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // Deframer state as the predictor tracks it.
  phase_e              pr_phase;
  logic                pr_fin;
  logic [3:0]          pr_opcode;
  logic                pr_masked;
  logic [LenWidth-1:0] pr_len;
  logic [LenWidth-1:0] pr_done;
  logic [2:0]          pr_hdr_cnt;
  logic [31:0]         pr_key;
  logic                pr_err;

  wsd_res_t    result_q[$];
  stim_row_t   dir_rows[$];
  logic [7:0]  frame_q[$];

  int n_fail;
  int n_checked;
  int n_sent;
  int n_frames;
  int burst_left;
  int hold_req;
  int hold_served;
  int cycles;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic wsd_res_t make_res(logic [7:0] d, logic v, logic l, logic e);
    wsd_res_t r;
    r.payload_byte   = d;
    r.byte_valid     = v;
    r.frame_last     = l;
    r.frame_opcode   = pr_opcode;
    r.fin_flag       = pr_fin;
    r.protocol_error = e;
    return r;
  endfunction

  function automatic void start_frame();
    pr_phase   = PhHdr1;
    pr_masked  = 1'b0;
    pr_len     = '0;
    pr_done    = '0;
    pr_hdr_cnt = '0;
    pr_key     = '0;
  endfunction

  function automatic bit header_done(output wsd_res_t r);
    r          = '0;
    pr_hdr_cnt = '0;
    pr_done    = '0;
    if (pr_masked) begin
      pr_phase = PhMask;
      return 1'b0;
    end
    if (pr_len == '0) begin
      start_frame();
      r = make_res(8'h00, 1'b0, 1'b1, 1'b0);
      return 1'b1;
    end
    pr_phase = PhData;
    return 1'b0;
  endfunction

  function automatic bit deframe_byte(input logic [7:0] b, output wsd_res_t r);
    logic [7:0] k;
    logic       last;
    r = '0;
    k = '0;
    if (pr_err) return 1'b0;
    case (pr_phase)
      PhHdr1: begin
        pr_fin    = b[7];
        pr_opcode = b[3:0];
        if ((b & HdrRsvMask) != '0) begin
          pr_err = 1'b1;
          r = make_res(8'h00, 1'b0, 1'b0, 1'b1);
          return 1'b1;
        end
        pr_phase = PhHdr2;
      end
      PhHdr2: begin
        pr_masked  = b[7];
        pr_len     = LenWidth'(b[6:0]);
        pr_hdr_cnt = '0;
        if (b[6:0] == LenExt16) begin
          pr_len   = '0;
          pr_phase = PhExt16;
        end else if (b[6:0] == LenExt64) begin
          pr_len   = '0;
          pr_phase = PhExt64;
        end else begin
          return header_done(r);
        end
      end
      PhExt16, PhExt64: begin
        pr_len     = {pr_len[LenWidth-9:0], b};
        pr_hdr_cnt = pr_hdr_cnt + 3'd1;
        if ((pr_phase == PhExt16 && pr_hdr_cnt == Ext16Bytes) ||
            (pr_phase == PhExt64 && pr_hdr_cnt == Ext64Wrap)) return header_done(r);
      end
      PhMask: begin
        pr_key     = {pr_key[23:0], b};
        pr_hdr_cnt = pr_hdr_cnt + 3'd1;
        if (pr_hdr_cnt == MaskKeyLen) begin
          pr_hdr_cnt = '0;
          if (pr_len == '0) begin
            start_frame();
            r = make_res(8'h00, 1'b0, 1'b1, 1'b0);
            return 1'b1;
          end
          pr_phase = PhData;
        end
      end
      PhData: begin
        // first key byte unmasks payload index 0 mod 4
        if (pr_masked) k = 8'(pr_key >> (5'd24 - {pr_done[1:0], 3'b000}));
        pr_done = pr_done + 1'b1;
        last    = (pr_done == pr_len);
        if (last) start_frame();
        r = make_res(b ^ k, 1'b1, last, 1'b0);
        return 1'b1;
      end
      default: start_frame();
    endcase
    return 1'b0;
  endfunction

  function automatic string fmt_res(wsd_res_t r);
    return $sformatf("data=%02h valid=%0d last=%0d opcode=%0h fin=%0d err=%0d",
                     r.payload_byte, r.byte_valid, r.frame_last, r.frame_opcode,
                     r.fin_flag, r.protocol_error);
  endfunction

  function automatic void add_row(logic [7:0] b, row_kind_e kind, wsd_res_t res);
    stim_row_t row;
    row.data = b;
    row.kind = kind;
    row.res  = res;
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  function automatic void add_frame_byte(logic [7:0] b);
    frame_q.insert(frame_q.size(), b);
  endfunction

  // Random well-formed frame: header, optional extended length, optional key, payload.
  task automatic build_frame(input int force_len);
    int          sel;
    logic [15:0] len;
    logic        masked;
    frame_q.delete();
    masked = 1'($urandom_range(0, 1));
    sel    = $urandom_range(0, 99);
    if (force_len >= 0) begin
      sel = 80;
      len = 16'(force_len);
    end else if (sel < 50) begin
      len = 16'($urandom_range(0, 6));
    end else if (sel < 72) begin
      len = 16'($urandom_range(7, 125));
    end else if ($urandom_range(0, 7) == 0) begin
      len = 16'($urandom_range(256, 300));
    end else begin
      len = 16'($urandom_range(0, 160));
    end
    add_frame_byte({1'($urandom_range(0, 1)), 3'b000, 4'($urandom_range(0, 15))});
    if (sel < 72) begin
      add_frame_byte({masked, len[6:0]});
    end else if (sel < 88) begin
      add_frame_byte({masked, LenExt16});
      add_frame_byte(len[15:8]);
      add_frame_byte(len[7:0]);
    end else begin
      add_frame_byte({masked, LenExt64});
      repeat (6) add_frame_byte(8'h00);
      add_frame_byte(len[15:8]);
      add_frame_byte(len[7:0]);
    end
    if (masked) repeat (4) add_frame_byte(8'($urandom_range(0, 255)));
    repeat (len) add_frame_byte(8'($urandom_range(0, 255)));
  endtask

  // Offer one item; idle in random bursts afterwards unless a hold-off is running.
  task automatic send_byte(input logic [7:0] b, input row_kind_e kind, input wsd_res_t typed,
                           input bit go_idle);
    wsd_res_t r;
    bit       has;
    int       gap;
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    has = deframe_byte(b, r);
    if (kind == RowTyped) begin
      has = 1'b1;
      r   = typed;
    end
    if (has) result_q.insert(result_q.size(), r);
    n_sent++;
    @(negedge clk_i);
    gap = 0;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 40);
      if (hold_req == hold_served && $urandom_range(0, 3) != 0) gap = $urandom_range(1, 8);
    end
    if (gap > 0 || go_idle) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk_i); while (result_q.size() != 0);
  endtask

  initial begin : stimulus
    int  tail_start;
    bit  hold_now;
    bit  pause_now;
    bit  held;
    bit  paused;
    rst_ni     = 1'b0;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    n_fail     = 0;
    n_checked  = 0;
    n_sent     = 0;
    n_frames   = 0;
    burst_left = 1;
    hold_req   = 0;
    held       = 1'b0;
    paused     = 1'b0;
    start_frame();
    pr_fin    = 1'b1;
    pr_opcode = '0;
    pr_err    = 1'b0;

    // typed results: {payload, valid, last, opcode, fin, err}
    add_row(8'h89, RowPred, '0);
    add_row(8'h00, RowTyped, wsd_res_t'({8'h00, 1'b0, 1'b1, 4'h9, 1'b1, 1'b0}));
    add_row(8'h8A, RowPred, '0);
    add_row(8'hFE, RowPred, '0);
    add_row(8'h00, RowPred, '0);
    add_row(8'h00, RowPred, '0);
    add_row(8'h12, RowPred, '0);
    add_row(8'h34, RowPred, '0);
    add_row(8'h56, RowPred, '0);
    add_row(8'h78, RowTyped, wsd_res_t'({8'h00, 1'b0, 1'b1, 4'hA, 1'b1, 1'b0}));
    add_row(8'h0F, RowPred, '0);
    add_row(8'hFF, RowPred, '0);
    repeat (7) add_row(8'h00, RowPred, '0);
    add_row(8'h02, RowPred, '0);
    add_row(8'hA5, RowPred, '0);
    add_row(8'h5A, RowPred, '0);
    add_row(8'hC3, RowPred, '0);
    add_row(8'h3C, RowPred, '0);
    add_row(8'h00, RowPred, '0);
    add_row(8'hFF, RowPred, '0);
    tail_start = dir_rows.size();
    add_row(8'hB3, RowTyped, wsd_res_t'({8'h00, 1'b0, 1'b0, 4'h3, 1'b1, 1'b1}));
    add_row(8'h81, RowPred, '0);

    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < tail_start; i++) begin
      send_byte(dir_rows[i].data, dir_rows[i].kind, dir_rows[i].res, 1'b0);
    end

    while (n_sent - tail_start < RandItems) begin
      hold_now  = !held && (n_sent - tail_start >= HoldAt);
      pause_now = !paused && (n_sent - tail_start >= PauseAt);
      build_frame(hold_now ? 200 : -1);
      if (hold_now) begin
        held = 1'b1;
        hold_req++;
      end
      for (int j = 0; j < frame_q.size(); j++) begin
        send_byte(frame_q[j], RowPred, '0, pause_now && (j == frame_q.size() - 1));
      end
      if (pause_now) begin
        paused = 1'b1;
        wait_drained();
      end
      n_frames++;
    end

    // reserved bits latch the error; drop everything after it
    for (int i = tail_start; i < dir_rows.size(); i++) begin
      send_byte(dir_rows[i].data, dir_rows[i].kind, dir_rows[i].res,
                i == dir_rows.size() - 1);
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    $display("Covered %0d bytes: directed frames, %0d random frames, a reserved-bit error",
             n_sent, n_frames);
    $display("Checked %0d results across a %0d-cycle receiver hold-off and a full drain",
             n_checked, HoldCycles);
    if (n_fail == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Mismatches: %0d", n_fail);
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : rx_stall
    rx_mode_e mode;
    int       seg;
    bit       toggle;
    m_tready    = 1'b0;
    hold_served = 0;
    toggle      = 1'b0;
    forever begin
      mode = rx_mode_e'($urandom_range(0, 3));
      seg  = $urandom_range(16, 160);
      repeat (seg) begin
        @(negedge clk_i);
        if (hold_req != hold_served) begin
          m_tready <= 1'b0;
          repeat (HoldCycles) @(negedge clk_i);
          hold_served++;
        end else begin
          case (mode)
            RxOpen:   m_tready <= 1'b1;
            RxRandom: m_tready <= 1'($urandom_range(0, 1));
            RxSparse: m_tready <= ($urandom_range(0, 3) == 0);
            default: begin
              toggle = ~toggle;
              m_tready <= toggle;
            end
          endcase
        end
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    wsd_res_t got;
    wsd_res_t want;
    if (rst_ni && m_axis_tvalid_o && m_tready) begin
      got.payload_byte   = m_axis_tdata_o[7:0];
      got.frame_opcode   = m_axis_tdata_o[11:8];
      got.fin_flag       = m_axis_tdata_o[12];
      got.byte_valid     = m_axis_tuser_o[0];
      got.protocol_error = m_axis_tuser_o[1];
      got.frame_last     = m_axis_tlast_o;
      if (result_q.size() == 0) begin
        if (n_fail < MaxReports) $display("ERROR: unexpected result %s", fmt_res(got));
        n_fail++;
      end else begin
        want = result_q.pop_front();
        n_checked++;
        if (got !== want) begin
          if (n_fail < MaxReports) begin
            $display("ERROR: result %0d mismatch", n_checked);
            $display("  expected %s", fmt_res(want));
            $display("  actual   %s", fmt_res(got));
          end
          n_fail++;
        end
      end
    end
  end

  initial begin : watchdog
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Timeout after %0d cycles, %0d results outstanding", cycles, result_q.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
